// ===== design/stable_min_priority_queue_defines.svh =====
// Assertion macros for the stable minimum priority queue.
// Included by smpq_datapath, the RTL file that carries concurrent assertions; no other dependencies.
`ifndef STABLE_MIN_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_MIN_PRIORITY_QUEUE_DEFINES_SVH

// condition holds at every clock edge out of reset
`define SMPQ_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// implication checked at every clock edge out of reset
`define SMPQ_ASSERT_IMPLY(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== design/smpq_pkg.sv =====
// Shared types and constants for the stable minimum priority queue.
// No dependencies.
`default_nettype none

package smpq_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int FILL_W = 5;

   typedef enum logic {
      MODE_ENQUEUE = 1'b0,
      MODE_DEQUEUE = 1'b1
   } smpq_mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } smpq_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } smpq_state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } smpq_cmd_type;

endpackage

`default_nettype wire

// ===== design/smpq_ctrl.sv =====
// Controller for the priority queue: sequences load, execute and response beats.
// Depends on smpq_pkg.
`default_nettype none

module smpq_ctrl
   import smpq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   output logic              rsp_strobe,
   output smpq_cmd_type      cmd
);

   smpq_state_type state_ff;
   smpq_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      cmd.load   = 1'b0;
      cmd.exec   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_strobe = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/smpq_datapath.sv =====
// Datapath for the priority queue: request latch, sorted shifting cell row,
// occupancy counter and result registers. Depends on smpq_pkg and the defines header.
`default_nettype none
`include "stable_min_priority_queue_defines.svh"

module smpq_datapath
   import smpq_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire smpq_cmd_type              cmd,
   input  wire logic                      req_mode,
   input  wire logic signed [DATA_W-1:0]  req_in_value,
   input  wire logic signed [DATA_W-1:0]  req_in_weight,
   output logic                           rsp_out_valid,
   output logic signed [DATA_W-1:0]       rsp_out_value,
   output logic signed [DATA_W-1:0]       rsp_out_weight,
   output logic [1:0]                     rsp_status,
   output logic [FILL_W-1:0]              rsp_fill_count
);

   smpq_mode_type            mode_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] weight_ff;

   logic signed [DATA_W-1:0] cell_value_ff  [DEPTH];
   logic signed [DATA_W-1:0] cell_weight_ff [DEPTH];
   logic signed [DATA_W-1:0] cell_value_in  [DEPTH];
   logic signed [DATA_W-1:0] cell_weight_in [DEPTH];

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic             out_valid_ff;
   logic [DATA_W-1:0] out_value_ff;
   logic [DATA_W-1:0] out_weight_ff;
   smpq_status_type  status_ff;
   logic [CNT_W-1:0] fill_ff;

   logic [DEPTH-1:0] le_vec;
   logic [DEPTH-1:0] ins_vec;
   logic             full;
   logic             empty;
   logic             do_enq;
   logic             do_deq;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff   <= smpq_mode_type'(req_mode);
         value_ff  <= req_in_value;
         weight_ff <= req_in_weight;
      end
   end

   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);
   assign do_enq = cmd.exec && (mode_ff == MODE_ENQUEUE) && !full;
   assign do_deq = cmd.exec && (mode_ff == MODE_DEQUEUE) && !empty;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign le_vec[i] = (count_ff > CNT_W'(i)) && (cell_weight_ff[i] <= weight_ff);

      if (i == 0) begin : g_first
         assign ins_vec[i] = !le_vec[i];
      end else begin : g_rest
         assign ins_vec[i] = !le_vec[i] && le_vec[i-1];
      end

      always_comb begin
         cell_value_in[i]  = cell_value_ff[i];
         cell_weight_in[i] = cell_weight_ff[i];
         if (mode_ff == MODE_DEQUEUE) begin
            if (i < DEPTH - 1) begin
               cell_value_in[i]  = cell_value_ff[(i + 1) % DEPTH];
               cell_weight_in[i] = cell_weight_ff[(i + 1) % DEPTH];
            end
         end else if (ins_vec[i]) begin
            cell_value_in[i]  = value_ff;
            cell_weight_in[i] = weight_ff;
         end else if (!le_vec[i] && i > 0) begin
            cell_value_in[i]  = cell_value_ff[(i + DEPTH - 1) % DEPTH];
            cell_weight_in[i] = cell_weight_ff[(i + DEPTH - 1) % DEPTH];
         end
      end

      always_ff @(posedge clock) begin
         if (do_enq || do_deq) begin
            cell_value_ff[i]  <= cell_value_in[i];
            cell_weight_ff[i] <= cell_weight_in[i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_enq) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_deq) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         out_valid_ff  <= do_deq;
         out_value_ff  <= do_deq ? cell_value_ff[0] : '0;
         out_weight_ff <= do_deq ? cell_weight_ff[0] : '0;
         fill_ff       <= count_in;
         if (mode_ff == MODE_ENQUEUE) begin
            status_ff <= full ? STATUS_FULL : STATUS_OK;
         end else begin
            status_ff <= empty ? STATUS_EMPTY : STATUS_OK;
         end
      end
   end

   assign rsp_out_valid  = out_valid_ff;
   assign rsp_out_value  = out_value_ff;
   assign rsp_out_weight = out_weight_ff;
   assign rsp_status     = status_ff;
   assign rsp_fill_count = FILL_W'(fill_ff);

   `SMPQ_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH),
      "occupancy above depth")
   `SMPQ_ASSERT_IMPLY(a_one_insert_slot, clock, reset, do_enq |-> $onehot(ins_vec),
      "sorted row has no single insertion point")
   `SMPQ_ASSERT_IMPLY(a_deq_count, clock, reset,
      do_deq |=> (count_ff == $past(count_ff) - CNT_W'(1)),
      "dequeue did not drop occupancy by one")

endmodule

`default_nettype wire

// ===== design/stable_min_priority_queue.sv =====
// Stable minimum priority queue, sorted shifting register row of smpq_pkg::DEPTH entries.
// A start in idle is latched, executed, then answered by a result beat (rsp_strobe).
// The load/execute/respond controller takes no new command until idle again (busy low).
// The receiver cannot stall; each result beat is valid for one cycle only.
// Reset (synchronous, active high) empties the queue and returns the controller to idle.
// Depends on smpq_pkg, smpq_ctrl and smpq_datapath.
`default_nettype none

module stable_min_priority_queue
   import smpq_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic                      req_mode,
   input  wire logic signed [DATA_W-1:0]  req_in_value,
   input  wire logic signed [DATA_W-1:0]  req_in_weight,
   output logic                           rsp_strobe,
   output logic                           rsp_out_valid,
   output logic signed [DATA_W-1:0]       rsp_out_value,
   output logic signed [DATA_W-1:0]       rsp_out_weight,
   output logic [1:0]                     rsp_status,
   output logic [FILL_W-1:0]              rsp_fill_count
);

   smpq_cmd_type cmd;

   smpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   smpq_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_mode       (req_mode),
      .req_in_value   (req_in_value),
      .req_in_weight  (req_in_weight),
      .rsp_out_valid  (rsp_out_valid),
      .rsp_out_value  (rsp_out_value),
      .rsp_out_weight (rsp_out_weight),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count)
   );

endmodule

`default_nettype wire
